// ===== rtl/pls_pkg.sv =====
package pls_pkg;

    // fixed field widths of the item ports
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int ELEM_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // parameter defaults
    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] tail;
    } pls_cmd_t;

endpackage

// ===== rtl/pls_cell.sv =====
module pls_cell #(
    parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  pls_pkg::pls_cmd_t     cmd,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] ins_data,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [DATA_WIDTH-1:0] hit_out
);

    localparam logic [pls_pkg::POS_W-1:0] MY_IDX = pls_pkg::POS_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            pls_pkg::CELL_INSERT: begin
                if (MY_IDX == cmd.pos) begin
                    data_next = ins_data;
                end else if (MY_IDX > cmd.pos) begin
                    data_next = left_data;
                end
            end
            pls_pkg::CELL_DELETE: begin
                if (MY_IDX >= cmd.pos) begin
                    data_next = right_data;
                end
            end
            pls_pkg::CELL_ROTATE: begin
                // tail cell wraps around to the head
                if (MY_IDX == cmd.tail) begin
                    data_next = head_data;
                end else if (MY_IDX < cmd.tail) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign hit_out  = (MY_IDX == cmd.pos) ? data_reg : '0;

endmodule

// ===== rtl/pls_ctrl.sv =====
module pls_ctrl #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pls_pkg::FUNC_W-1:0]       s_func,
    input  logic [pls_pkg::POS_W-1:0]        s_position,
    input  logic [pls_pkg::ELEM_W-1:0]       head_data,
    input  logic [pls_pkg::ELEM_W-1:0]       removed_data,
    output pls_pkg::pls_cmd_t                cmd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [pls_pkg::ELEM_W-1:0]       m_element,
    output logic [pls_pkg::INDEX_W-1:0]      m_index,
    output logic [pls_pkg::COUNT_W-1:0]      m_count,
    output logic [pls_pkg::STATUS_W-1:0]     m_status,
    output logic                             m_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                              state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  dump_idx_reg, dump_idx_next;
    logic                              m_valid_reg, m_valid_next;
    logic [pls_pkg::ELEM_W-1:0]        m_element_reg, m_element_next;
    logic [pls_pkg::INDEX_W-1:0]       m_index_reg, m_index_next;
    logic [pls_pkg::COUNT_W-1:0]       m_count_reg, m_count_next;
    logic [pls_pkg::STATUS_W-1:0]      m_status_reg, m_status_next;
    logic                              m_last_reg, m_last_next;

    logic             out_free;
    logic             accept;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0] tail_cnt;
    logic             dump_go;
    logic             dump_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_ext  = CMP_W'(s_position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign tail_cnt = count_reg - CNT_W'(1);

    // a dump emits its first element at acceptance, the rest from S_DUMP
    assign dump_go   = (accept && (s_func == pls_pkg::FUNC_DUMP) && !empty)
                     || ((state_reg == S_DUMP) && out_free);
    assign dump_last = (dump_idx_reg == tail_cnt);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_element_next = m_element_reg;
        m_index_next   = m_index_reg;
        m_count_next   = m_count_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        cmd.op         = pls_pkg::CELL_HOLD;
        cmd.pos        = s_position;
        cmd.tail       = pls_pkg::POS_W'(tail_cnt);

        if (dump_go) begin
            cmd.op         = pls_pkg::CELL_ROTATE;
            m_valid_next   = 1'b1;
            m_element_next = head_data;
            m_index_next   = pls_pkg::INDEX_W'(dump_idx_reg);
            m_count_next   = pls_pkg::COUNT_W'(count_reg);
            m_status_next  = pls_pkg::STATUS_OK;
            m_last_next    = dump_last;
            if (dump_last) begin
                state_next    = S_IDLE;
                dump_idx_next = '0;
            end else begin
                state_next    = S_DUMP;
                dump_idx_next = dump_idx_reg + CNT_W'(1);
            end
        end else if (accept) begin
            m_valid_next   = 1'b1;
            m_element_next = '0;
            m_index_next   = '0;
            m_status_next  = pls_pkg::STATUS_OK;
            m_last_next    = 1'b1;
            case (s_func)
                pls_pkg::FUNC_INSERT: begin
                    if (full) begin
                        m_status_next = pls_pkg::STATUS_FULL;
                    end else if (pos_ext > cnt_ext) begin
                        m_status_next = pls_pkg::STATUS_RANGE;
                    end else begin
                        cmd.op     = pls_pkg::CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                pls_pkg::FUNC_DELETE: begin
                    if (empty) begin
                        m_status_next = pls_pkg::STATUS_EMPTY;
                    end else if (pos_ext >= cnt_ext) begin
                        m_status_next = pls_pkg::STATUS_RANGE;
                    end else begin
                        cmd.op         = pls_pkg::CELL_DELETE;
                        count_next     = count_reg - CNT_W'(1);
                        m_element_next = removed_data;
                        m_index_next   = pls_pkg::INDEX_W'(s_position);
                    end
                end
                pls_pkg::FUNC_DUMP: begin
                    // only reached on an empty store
                    m_status_next = pls_pkg::STATUS_EMPTY;
                end
                default: begin
                    m_status_next = pls_pkg::STATUS_OK;
                end
            endcase
            m_count_next = pls_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_element_reg <= m_element_next;
        m_index_reg   <= m_index_next;
        m_count_reg   <= m_count_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_element = m_element_reg;
    assign m_index   = m_index_reg;
    assign m_count   = m_count_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

endmodule

// ===== rtl/positional_list_store_unit.sv =====
// positional list store: an ordered sequence of up to CAPACITY values held in
// a row of cells, cell i holding element i. insert (func 0) places s_value at
// s_position (0..count) and every cell above that position takes its left
// neighbor, all in the cycle of acceptance. delete (func 1) returns the
// element at s_position (0..count-1) and the cells above close the gap.
// dump (func 2) rotates the occupied cells left by one place per cycle
// while the output is free, sending the head cell out each time, so after
// count results the store is back as it was; m_last marks the final
// element. a full store, a position out of range and an empty store give
// one item with a status and leave the store unchanged; func 3 gives one
// item with status ok. insert, delete, errors and func 3 each give a single
// result; a dump gives one result per cycle while m_ready is high, set by
// the single head-to-output path of the rotating cell row. one item is in
// work at a time; the result sits in an output register, so s_ready only
// needs that register to be free or emptying in the same cycle. stored
// values keep the low DATA_WIDTH bits of s_value and come back zero-extended
module positional_list_store_unit #(
    parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pls_pkg::FUNC_W-1:0]          s_func,
    input  logic [pls_pkg::POS_W-1:0]           s_position,
    input  logic signed [pls_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pls_pkg::ELEM_W-1:0]   m_element,
    output logic [pls_pkg::INDEX_W-1:0]         m_index,
    output logic [pls_pkg::COUNT_W-1:0]         m_count,
    output logic [pls_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_last
);

    // command broadcast to every cell
    pls_pkg::pls_cmd_t cmd;

    // cell row contents and the per-cell read taps used by delete
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_hit  [CAPACITY];
    logic [DATA_WIDTH-1:0] ins_data;
    logic [DATA_WIDTH-1:0] hit_or;

    logic [pls_pkg::ELEM_W-1:0] head_data;
    logic [pls_pkg::ELEM_W-1:0] removed_data;
    logic [pls_pkg::ELEM_W-1:0] element_raw;

    // keep the low DATA_WIDTH bits, zero-extended where the store is wider
    assign ins_data = DATA_WIDTH'($unsigned(s_value));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;

            // head cell takes the new value on its left side
            if (gi == 0) begin : g_head
                assign left_d = ins_data;
            end else begin : g_mid
                assign left_d = cell_data[gi-1];
            end

            // far end has no right neighbor; on a delete it keeps its own value
            if (gi == CAPACITY - 1) begin : g_end
                assign right_d = cell_data[gi];
            end else begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            pls_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (gi)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .ins_data   (ins_data),
                .data_out   (cell_data[gi]),
                .hit_out    (cell_hit[gi])
            );
        end
    endgenerate

    // at most one cell matches the position, so an or of the taps reads it
    always_comb begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_or = hit_or | cell_hit[i];
        end
    end

    assign head_data    = pls_pkg::ELEM_W'(cell_data[0]);
    assign removed_data = pls_pkg::ELEM_W'(hit_or);

    pls_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .head_data    (head_data),
        .removed_data (removed_data),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_element    (element_raw),
        .m_index      (m_index),
        .m_count      (m_count),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    assign m_element = element_raw;

endmodule

// ===== rtl/pls_checker.sv =====
module pls_checker #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [pls_pkg::ELEM_W-1:0]       m_element,
    input logic [pls_pkg::INDEX_W-1:0]      m_index,
    input logic [pls_pkg::COUNT_W-1:0]      m_count,
    input logic [pls_pkg::STATUS_W-1:0]     m_status,
    input logic                             m_last
);

    localparam logic [pls_pkg::COUNT_W-1:0] CAP_CNT = pls_pkg::COUNT_W'(CAPACITY);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_index)
            && $stable(m_count) && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    // every accepted item produces a result in the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after accepted item");

    // an error result is always the only result of its item
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != pls_pkg::STATUS_OK |-> m_last)
        else $error("error result not marked last");

    // empty status only with an empty store
    a_empty_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pls_pkg::STATUS_EMPTY |-> m_count == '0)
        else $error("empty status with nonzero count");

    // full status only with a full store
    a_full_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pls_pkg::STATUS_FULL |-> m_count == CAP_CNT)
        else $error("full status with count below capacity");

endmodule

bind positional_list_store_unit pls_checker #(
    .CAPACITY (CAPACITY)
) u_pls_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_element (m_element),
    .m_index   (m_index),
    .m_count   (m_count),
    .m_status  (m_status),
    .m_last    (m_last)
);

// ===== tb/positional_list_store_unit_test.sv =====
`timescale 1ns / 100ps

module positional_list_store_unit_test;

    import pls_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int POS_TOP      = 32;
    localparam int WAIT_MAX     = 18;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 2 * CAP + 8;
    localparam int LIMIT_CYCLES = 1000000;

    // func 3 has no name in the package; the unit answers it with a plain ok
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    typedef struct {
        logic [ELEM_W-1:0]   element;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
        logic                last;
    } store_reply_t;

    // shadow copy of the ordered store and the replies it still owes
    class list_shadow;
        logic [ELEM_W-1:0] cells [CAP];
        int unsigned       fill;
        store_reply_t      owed [$];
        int unsigned       failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        function void owe(logic [ELEM_W-1:0] element, logic [INDEX_W-1:0] index,
                          logic [STATUS_W-1:0] status, logic last);
            store_reply_t r;
            r.element = element;
            r.index   = index;
            r.count   = COUNT_W'(fill);
            r.status  = status;
            r.last    = last;
            owed.push_back(r);
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] value);
            int unsigned       i;
            logic [ELEM_W-1:0] removed;
            case (func)
                FUNC_INSERT: begin
                    if (fill >= CAP) begin
                        owe('0, '0, STATUS_FULL, 1'b1);
                    end else if (pos > fill) begin
                        owe('0, '0, STATUS_RANGE, 1'b1);
                    end else begin
                        for (i = fill; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = value;
                        fill++;
                        owe('0, '0, STATUS_OK, 1'b1);
                    end
                end
                FUNC_DELETE: begin
                    if (fill == 0) begin
                        owe('0, '0, STATUS_EMPTY, 1'b1);
                    end else if (pos >= fill) begin
                        owe('0, '0, STATUS_RANGE, 1'b1);
                    end else begin
                        removed = cells[pos];
                        for (i = pos; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                        owe(removed, pos[INDEX_W-1:0], STATUS_OK, 1'b1);
                    end
                end
                FUNC_DUMP: begin
                    if (fill == 0)
                        owe('0, '0, STATUS_EMPTY, 1'b1);
                    for (i = 0; i < fill; i++)
                        owe(cells[i], INDEX_W'(i), STATUS_OK, i + 1 == fill);
                end
                default: begin
                    owe('0, '0, STATUS_OK, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_reply(store_reply_t got);
            store_reply_t want;
            if (owed.size() == 0) begin
                $error("result with nothing pending: element %0h index %0d status %0d",
                       got.element, got.index, got.status);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("element", want.element, got.element);
            compare_field("index", 32'(want.index), 32'(got.index));
            compare_field("count", 32'(want.count), 32'(got.count));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                       aclk       = 1'b0;
    logic                       aresetn    = 1'b0;
    logic                       s_valid    = 1'b0;
    logic                       s_ready;
    logic [FUNC_W-1:0]          s_func     = FUNC_INSERT;
    logic [POS_W-1:0]           s_position = '0;
    logic signed [VALUE_W-1:0]  s_value    = '0;
    logic                       m_valid;
    logic                       m_ready    = 1'b1;
    logic signed [ELEM_W-1:0]   m_element;
    logic [INDEX_W-1:0]         m_index;
    logic [COUNT_W-1:0]         m_count;
    logic [STATUS_W-1:0]        m_status;
    logic                       m_last;

    list_shadow  sb;
    bit          send_calm = 1'b0;
    bit          take_calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;

    positional_list_store_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_position (s_position),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_element  (m_element),
        .m_index    (m_index),
        .m_count    (m_count),
        .m_status   (m_status),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    // hard stop in case the unit hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("positional_list_store_unit test failed");
            $finish;
        end
    end

    function automatic int wait_draw(bit calm);
        return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    // mostly random words, with the signed extremes and all-ones mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // called at a rising edge; valid stays up across back-to-back items
    task automatic send_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] value);
        int gap;
        gap = wait_draw(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_position <= pos;
        s_value    <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(func, pos, value);
        items_sent++;
    endtask

    // steers the fill level toward a target, with dumps, noise and bad positions
    task automatic send_random_item(int unsigned target);
        int unsigned fill;
        int unsigned r;
        fill = sb.fill;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            if (fill < target)
                send_request(FUNC_INSERT, POS_W'($urandom_range(0, fill)), pick_value());
            else if (fill > target)
                send_request(FUNC_DELETE, POS_W'($urandom_range(0, fill - 1)),
                             pick_value());
            else if (fill == CAP)
                send_request(FUNC_INSERT, POS_W'($urandom_range(0, POS_TOP)),
                             pick_value());
            else if (fill == 0)
                send_request(FUNC_DELETE, POS_W'($urandom_range(0, POS_TOP)),
                             pick_value());
            else if (r[0])
                send_request(FUNC_INSERT, POS_W'($urandom_range(0, fill)), pick_value());
            else
                send_request(FUNC_DELETE, POS_W'($urandom_range(0, fill - 1)),
                             pick_value());
        end else if (r < 80) begin
            send_request(FUNC_DUMP, POS_W'($urandom_range(0, POS_TOP)), pick_value());
        end else if (r < 95) begin
            send_request(FUNC_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, POS_TOP)),
                         pick_value());
        end else if (r[0] && fill < CAP) begin
            send_request(FUNC_INSERT, POS_W'($urandom_range(fill + 1, POS_TOP)),
                         pick_value());
        end else begin
            send_request(FUNC_DELETE, POS_W'($urandom_range(fill, POS_TOP)), pick_value());
        end
    endtask

    // result side: random stalls, occasionally switching to a stall-free stretch
    initial begin
        store_reply_t got;
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = wait_draw(take_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.element = m_element;
            got.index   = m_index;
            got.count   = m_count;
            got.status  = m_status;
            got.last    = m_last;
            sb.check_reply(got);
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
        end
    end

    initial begin
        int unsigned target;
        int unsigned steps;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store corner cases
        send_request(FUNC_DELETE, 6'd0, 32'h0);
        send_request(FUNC_DUMP, 6'd0, 32'h0);
        send_request(FUNC_UNKNOWN, 6'd5, 32'h1234_5678);
        send_request(FUNC_INSERT, 6'd1, 32'h0);
        send_request(FUNC_INSERT, 6'd32, 32'hffff_ffff);

        // build a short list through back, front and middle inserts
        send_request(FUNC_INSERT, 6'd0, 32'h8000_0000);
        send_request(FUNC_INSERT, 6'd1, 32'h7fff_ffff);
        send_request(FUNC_INSERT, 6'd0, 32'hffff_ffff);
        send_request(FUNC_INSERT, 6'd1, 32'h0000_0000);
        send_request(FUNC_INSERT, 6'd4, 32'h5555_aaaa);
        send_request(FUNC_DUMP, 6'd63, 32'h0);

        // delete past the end, then at back, front and middle
        send_request(FUNC_DELETE, 6'd5, 32'h0);
        send_request(FUNC_DELETE, 6'd32, 32'h0);
        send_request(FUNC_DELETE, 6'd4, 32'h0);
        send_request(FUNC_DELETE, 6'd0, 32'h0);
        send_request(FUNC_DELETE, 6'd1, 32'h0);
        send_request(FUNC_DUMP, 6'd0, 32'h0);
        send_request(FUNC_DELETE, 6'd1, 32'h0);
        // back delete on a single element
        send_request(FUNC_DELETE, 6'd0, 32'h0);
        send_request(FUNC_UNKNOWN, 6'd32, 32'hffff_ffff);
        send_request(FUNC_DUMP, 6'd0, 32'h0);

        // random segments, each heading for empty, full or somewhere between
        while (items_sent < 21 + RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: target = 0;
                1: target = CAP;
                default: target = $urandom_range(1, CAP - 1);
            endcase
            send_calm = ($urandom_range(0, 3) == 0);
            steps = $urandom_range(20, 60);
            repeat (steps) begin
                if (items_sent < 21 + RANDOM_ITEMS)
                    send_random_item(target);
            end
        end
        s_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0)
            $display("positional_list_store_unit test passed");
        else
            $display("positional_list_store_unit test failed");
        $finish;
    end

endmodule
